/* design/lts_pkg.sv */
// Shared types, sizes and constant tables for the lexical tokenizer.
// Used by lts_ctrl, lts_dpath and the top level.
// No dependencies.
`default_nettype none

package lts_pkg;

    // Sizing
    localparam int MAX_NAME_LEN = 16;
    localparam int IDENT_DEPTH  = 64;
    localparam int CONST_DEPTH  = 64;

    localparam int NAME_W  = 8 * MAX_NAME_LEN;
    localparam int CNAME_W = 4 * MAX_NAME_LEN;
    localparam int CNT_W   = $clog2(MAX_NAME_LEN + 2);
    localparam int NIDX_W  = $clog2(MAX_NAME_LEN);
    localparam int IIDX_W  = (IDENT_DEPTH > 1) ? $clog2(IDENT_DEPTH) : 1;
    localparam int CIDX_W  = (CONST_DEPTH > 1) ? $clog2(CONST_DEPTH) : 1;
    localparam int IUSED_W = $clog2(IDENT_DEPTH + 1);
    localparam int CUSED_W = $clog2(CONST_DEPTH + 1);
    localparam int USED_W  = (IUSED_W > CUSED_W) ? IUSED_W : CUSED_W;

    localparam int LEN_W   = 6;
    localparam int CODE_W  = 10;
    localparam int POS_W   = 16;
    localparam int ERR_W   = 3;
    localparam int TDATA_W = 56;

    // Token code bases
    localparam logic [CODE_W-1:0] CODE_CONST   = 10'd400;
    localparam logic [CODE_W-1:0] CODE_KEYWORD = 10'd700;
    localparam logic [CODE_W-1:0] CODE_IDENT   = 10'd800;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_BAD   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_DELIM = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OPEN  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_FULL  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LONG  = 3'd4;

    // Keyword table, text right-justified (first char in the top byte used)
    localparam int KW_NUM = 10;
    localparam logic [79:0] KW_TEXT [KW_NUM] = '{
        80'("PROGRAM"), 80'("BEGIN"), 80'("END"), 80'("VA"), 80'("SIGNAL"),
        80'("COMPLEX"), 80'("INTEGER"), 80'("FLOAT"), 80'("BLOCKFLOAT"), 80'("EXT")
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd7, 4'd5, 4'd3, 4'd2, 4'd6, 4'd7, 4'd7, 4'd5, 4'd10, 4'd3
    };

    // Scanner mode
    typedef enum logic [5:0] {
        MD_IDLE    = 6'b000001,
        MD_IDENT   = 6'b000010,
        MD_DIGIT   = 6'b000100,
        MD_PAREN   = 6'b001000,
        MD_COMMENT = 6'b010000,
        MD_STAR    = 6'b100000
    } mode_t;

    // Result that precedes a name finish or a restart
    typedef enum logic [1:0] {
        PRE_NONE  = 2'd0,
        PRE_ERR1  = 2'd1,
        PRE_PAREN = 2'd2,
        PRE_ERR2  = 2'd3
    } pre_t;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_PLAN  = 4'd2,
        OP_PRE   = 4'd3,
        OP_FCHK  = 4'd4,
        OP_SRCH  = 4'd5,
        OP_CMP   = 4'd6,
        OP_INS   = 4'd7,
        OP_FIN   = 4'd8,
        OP_START = 4'd9
    } op_t;

    // Datapath status toward the controller
    typedef struct packed {
        pre_t dec_pre;
        logic dec_fin;
        logic dec_start;
        logic fin;
        logic start;
        logic start_emits;
        logic fin_direct;
        logic used_zero;
        logic cmp_hit;
        logic srch_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] idx;
    } kw_t;

    // Keyword match against the name buffer (lowest index wins)
    function automatic kw_t kw_lookup(input logic [NAME_W-1:0] name,
                                      input logic [CNT_W-1:0] cnt);
        kw_t  r;
        logic eq;
        int   sh;
        r = '0;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            eq = (CNT_W'(KW_LEN[k]) == cnt);
            for (int i = 0; i < 10; i++) begin
                sh = (i < int'(KW_LEN[k])) ? int'(KW_LEN[k]) - 1 - i : 0;
                if ((i < int'(KW_LEN[k])) && (name[8*i +: 8] != KW_TEXT[k][8*sh +: 8])) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                r.hit = 1'b1;
                r.idx = 4'(k);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/lts_dpath.sv */
// Tokenizer datapath: item register, scanner mode, name buffer, position
// counters, symbol table memories and the output register.
// Depends on lts_pkg.
`default_nettype none

module lts_dpath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire lts_pkg::op_t                op,
    input  wire logic [7:0]                  s_tdata,
    input  wire logic                        s_tuser,
    output lts_pkg::status_t                 st,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [lts_pkg::TDATA_W-1:0]      m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    // Item and plan registers
    logic                          req_reg;
    logic [7:0]                    chr_reg;
    lts_pkg::mode_t                mode_reg;
    lts_pkg::pre_t                 pre_reg;
    logic                          fin_reg, start_reg;
    logic [1:0]                    ntot_reg, ridx_reg;

    // Name and position state
    logic [lts_pkg::NAME_W-1:0]    name_reg;
    logic [lts_pkg::CNT_W-1:0]     cnt_reg;
    logic [lts_pkg::POS_W-1:0]     line_reg, col_reg, tcol_reg;

    // Symbol tables
    logic [lts_pkg::IUSED_W-1:0]   iused_reg;
    logic [lts_pkg::CUSED_W-1:0]   cused_reg;
    logic [lts_pkg::USED_W-1:0]    sidx_reg;
    logic [lts_pkg::CNT_W+lts_pkg::NAME_W-1:0]  imem [lts_pkg::IDENT_DEPTH];
    logic [lts_pkg::CNT_W+lts_pkg::CNAME_W-1:0] cmem [lts_pkg::CONST_DEPTH];
    logic [lts_pkg::CNT_W+lts_pkg::NAME_W-1:0]  irow_reg;
    logic [lts_pkg::CNT_W+lts_pkg::CNAME_W-1:0] crow_reg;

    // Finish result
    logic                          ferr_reg;
    logic [lts_pkg::ERR_W-1:0]     fecode_reg;
    logic [lts_pkg::CODE_W-1:0]    fcode_reg;

    // Output register
    logic                          ov_reg, olast_reg, okind_reg;
    logic [lts_pkg::TDATA_W-1:0]   odata_reg;

    // Character classes
    logic is_letter, is_digit, is_space, is_delim, is_lpar, is_star, is_rpar;
    assign is_letter = (chr_reg >= 8'h41) && (chr_reg <= 8'h5A);
    assign is_digit  = (chr_reg >= 8'h30) && (chr_reg <= 8'h39);
    assign is_space  = ((chr_reg >= 8'd8) && (chr_reg <= 8'd15)) || (chr_reg == 8'h20);
    assign is_lpar   = (chr_reg == 8'h28);
    assign is_star   = (chr_reg == 8'h2A);
    assign is_rpar   = (chr_reg == 8'h29);
    assign is_delim  = (chr_reg == 8'h3B) || (chr_reg == 8'h2C) || (chr_reg == 8'h3A)
                    || is_lpar || is_rpar;

    logic is_ident, too_long, start_emits, ifull, cfull;
    assign is_ident    = (mode_reg == lts_pkg::MD_IDENT);
    assign too_long    = (cnt_reg > lts_pkg::CNT_W'(lts_pkg::MAX_NAME_LEN));
    assign start_emits = !is_space && !is_letter && !is_digit && !is_lpar;
    assign ifull       = (iused_reg == lts_pkg::IUSED_W'(lts_pkg::IDENT_DEPTH));
    assign cfull       = (cused_reg == lts_pkg::CUSED_W'(lts_pkg::CONST_DEPTH));

    lts_pkg::kw_t kw;
    assign kw = lts_pkg::kw_lookup(name_reg, cnt_reg);

    // Decode of the loaded item against the current mode
    lts_pkg::pre_t dec_pre;
    logic          dec_fin, dec_start;
    always_comb begin
        dec_pre   = lts_pkg::PRE_NONE;
        dec_fin   = 1'b0;
        dec_start = 1'b0;
        if (req_reg) begin
            unique case (mode_reg)
                lts_pkg::MD_IDENT, lts_pkg::MD_DIGIT: dec_fin = 1'b1;
                lts_pkg::MD_PAREN:                    dec_pre = lts_pkg::PRE_PAREN;
                lts_pkg::MD_COMMENT, lts_pkg::MD_STAR: dec_pre = lts_pkg::PRE_ERR2;
                default: ;
            endcase
        end else begin
            unique case (mode_reg)
                lts_pkg::MD_IDENT: begin
                    if (!(is_letter || is_digit)) begin
                        dec_fin   = 1'b1;
                        dec_start = 1'b1;
                    end
                end
                lts_pkg::MD_DIGIT: begin
                    if (is_space || is_delim) begin
                        dec_fin   = 1'b1;
                        dec_start = 1'b1;
                    end else if (!is_digit) begin
                        dec_pre = lts_pkg::PRE_ERR1;
                        dec_fin = 1'b1;
                    end
                end
                lts_pkg::MD_PAREN: begin
                    if (!is_star) begin
                        dec_pre   = lts_pkg::PRE_PAREN;
                        dec_start = 1'b1;
                    end
                end
                lts_pkg::MD_COMMENT, lts_pkg::MD_STAR: ;
                default: dec_start = 1'b1;
            endcase
        end
    end

    // Table compare on the registered row
    logic cmp_hit;
    always_comb begin
        if (is_ident) begin
            cmp_hit = (irow_reg[lts_pkg::CNT_W+lts_pkg::NAME_W-1 -: lts_pkg::CNT_W] == cnt_reg);
            for (int i = 0; i < lts_pkg::MAX_NAME_LEN; i++) begin
                if ((i < int'(cnt_reg)) && (irow_reg[8*i +: 8] != name_reg[8*i +: 8])) begin
                    cmp_hit = 1'b0;
                end
            end
        end else begin
            cmp_hit = (crow_reg[lts_pkg::CNT_W+lts_pkg::CNAME_W-1 -: lts_pkg::CNT_W] == cnt_reg);
            for (int i = 0; i < lts_pkg::MAX_NAME_LEN; i++) begin
                if ((i < int'(cnt_reg)) && (crow_reg[4*i +: 4] != name_reg[8*i +: 4])) begin
                    cmp_hit = 1'b0;
                end
            end
        end
    end

    logic [lts_pkg::CNAME_W-1:0] cname;
    always_comb begin
        for (int i = 0; i < lts_pkg::MAX_NAME_LEN; i++) begin
            cname[4*i +: 4] = name_reg[8*i +: 4];
        end
    end

    logic [lts_pkg::USED_W-1:0] sel_used, sidx_inc;
    assign sel_used = is_ident ? lts_pkg::USED_W'(iused_reg) : lts_pkg::USED_W'(cused_reg);
    assign sidx_inc = sidx_reg + 1'b1;

    logic out_free;
    assign out_free = !ov_reg || m_tready;

    // Status
    always_comb begin
        st.dec_pre     = dec_pre;
        st.dec_fin     = dec_fin;
        st.dec_start   = dec_start;
        st.fin         = fin_reg;
        st.start       = start_reg;
        st.start_emits = start_emits;
        st.fin_direct  = too_long || (is_ident && kw.hit);
        st.used_zero   = (sel_used == '0);
        st.cmp_hit     = cmp_hit;
        st.srch_last   = (sidx_inc == sel_used);
        st.out_free    = out_free;
    end

    // Saturating position steps
    logic [lts_pkg::POS_W-1:0] col_inc, line_inc;
    assign col_inc  = (col_reg == '1) ? col_reg : col_reg + 1'b1;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    // Result selection
    logic                       e_en, e_err;
    logic [lts_pkg::CODE_W-1:0] e_code;
    logic [lts_pkg::LEN_W-1:0]  e_len;
    logic [lts_pkg::POS_W-1:0]  e_col;
    logic [lts_pkg::ERR_W-1:0]  e_ecode;
    logic [lts_pkg::LEN_W-1:0]  cnt_len;
    assign cnt_len = lts_pkg::LEN_W'(cnt_reg);

    always_comb begin
        e_en    = 1'b0;
        e_err   = 1'b0;
        e_code  = '0;
        e_len   = '0;
        e_col   = col_reg;
        e_ecode = lts_pkg::ERR_BAD;
        case (op)
            lts_pkg::OP_PRE: begin
                e_en = 1'b1;
                case (pre_reg)
                    lts_pkg::PRE_PAREN: begin
                        e_code = 10'h028;
                        e_len  = 6'd1;
                        e_col  = tcol_reg;
                    end
                    lts_pkg::PRE_ERR1: begin
                        e_err   = 1'b1;
                        e_ecode = lts_pkg::ERR_DELIM;
                    end
                    default: begin
                        e_err   = 1'b1;
                        e_ecode = lts_pkg::ERR_OPEN;
                    end
                endcase
            end
            lts_pkg::OP_FIN: begin
                e_en    = 1'b1;
                e_err   = ferr_reg;
                e_col   = tcol_reg;
                e_ecode = ferr_reg ? fecode_reg : lts_pkg::ERR_BAD;
                e_code  = ferr_reg ? '0 : fcode_reg;
                e_len   = ferr_reg ? '0 : cnt_len;
            end
            lts_pkg::OP_START: begin
                if (start_emits) begin
                    e_en = 1'b1;
                    if (is_delim) begin
                        e_code = lts_pkg::CODE_W'(chr_reg);
                        e_len  = 6'd1;
                    end else begin
                        e_err = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lts_pkg::MD_IDLE;
            cnt_reg   <= '0;
            line_reg  <= 16'd1;
            col_reg   <= 16'd1;
            tcol_reg  <= 16'd1;
            iused_reg <= '0;
            cused_reg <= '0;
            ov_reg    <= 1'b0;
            ridx_reg  <= '0;
            ntot_reg  <= '0;
            pre_reg   <= lts_pkg::PRE_NONE;
            fin_reg   <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                ov_reg <= 1'b0;
            end
            if (e_en) begin
                ov_reg   <= 1'b1;
                ridx_reg <= ridx_reg + 1'b1;
            end
            case (op)
                lts_pkg::OP_PLAN: begin
                    pre_reg   <= dec_pre;
                    fin_reg   <= dec_fin;
                    start_reg <= dec_start;
                    ridx_reg  <= '0;
                    ntot_reg  <= 2'((dec_pre != lts_pkg::PRE_NONE)) + 2'(dec_fin)
                               + 2'(dec_start && start_emits);
                    if ((dec_pre == lts_pkg::PRE_NONE) && !dec_fin && !dec_start) begin
                        if (req_reg) begin
                            mode_reg <= lts_pkg::MD_IDLE;
                            cnt_reg  <= '0;
                        end else begin
                            unique case (mode_reg)
                                lts_pkg::MD_IDENT, lts_pkg::MD_DIGIT: begin
                                    if (cnt_reg < lts_pkg::CNT_W'(lts_pkg::MAX_NAME_LEN)) begin
                                        cnt_reg <= cnt_reg + 1'b1;
                                    end else begin
                                        cnt_reg <= lts_pkg::CNT_W'(lts_pkg::MAX_NAME_LEN + 1);
                                    end
                                    col_reg <= col_inc;
                                end
                                lts_pkg::MD_PAREN: begin
                                    mode_reg <= lts_pkg::MD_COMMENT;
                                    col_reg  <= col_inc;
                                end
                                default: begin
                                    // comment body; star and close tracking
                                    if (mode_reg == lts_pkg::MD_COMMENT) begin
                                        if (is_star) mode_reg <= lts_pkg::MD_STAR;
                                    end else if (is_rpar) begin
                                        mode_reg <= lts_pkg::MD_IDLE;
                                    end else if (!is_star) begin
                                        mode_reg <= lts_pkg::MD_COMMENT;
                                    end
                                    if (chr_reg == 8'd10) begin
                                        line_reg <= line_inc;
                                        col_reg  <= 16'd1;
                                    end else begin
                                        col_reg <= col_inc;
                                    end
                                end
                            endcase
                        end
                    end
                end
                lts_pkg::OP_PRE: begin
                    if (pre_reg == lts_pkg::PRE_ERR1) begin
                        col_reg <= col_inc;
                    end
                    if (req_reg) begin
                        mode_reg <= lts_pkg::MD_IDLE;
                        cnt_reg  <= '0;
                    end
                end
                lts_pkg::OP_INS: begin
                    if (is_ident) begin
                        if (!ifull) iused_reg <= iused_reg + 1'b1;
                    end else begin
                        if (!cfull) cused_reg <= cused_reg + 1'b1;
                    end
                end
                lts_pkg::OP_FIN: begin
                    mode_reg <= lts_pkg::MD_IDLE;
                    cnt_reg  <= '0;
                end
                lts_pkg::OP_START: begin
                    mode_reg <= lts_pkg::MD_IDLE;
                    if (is_space) begin
                        if (chr_reg == 8'd10) begin
                            line_reg <= line_inc;
                            col_reg  <= 16'd1;
                        end else begin
                            col_reg <= col_inc;
                        end
                    end else begin
                        col_reg <= col_inc;
                        if (is_letter || is_digit || is_lpar) begin
                            tcol_reg <= col_reg;
                        end
                        if (is_letter) begin
                            mode_reg <= lts_pkg::MD_IDENT;
                            cnt_reg  <= lts_pkg::CNT_W'(1);
                        end else if (is_digit) begin
                            mode_reg <= lts_pkg::MD_DIGIT;
                            cnt_reg  <= lts_pkg::CNT_W'(1);
                        end else if (is_lpar) begin
                            mode_reg <= lts_pkg::MD_PAREN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (op == lts_pkg::OP_LOAD) begin
            req_reg <= s_tuser;
            chr_reg <= s_tdata;
        end
        // name buffer append
        if ((op == lts_pkg::OP_PLAN) && !req_reg && (dec_pre == lts_pkg::PRE_NONE)
            && !dec_fin && !dec_start && (cnt_reg < lts_pkg::CNT_W'(lts_pkg::MAX_NAME_LEN))
            && ((mode_reg == lts_pkg::MD_IDENT) || (mode_reg == lts_pkg::MD_DIGIT))) begin
            name_reg[8*cnt_reg[lts_pkg::NIDX_W-1:0] +: 8] <=
                is_ident ? chr_reg : (chr_reg - 8'h30);
        end
        if ((op == lts_pkg::OP_START) && (is_letter || is_digit)) begin
            name_reg[7:0] <= is_letter ? chr_reg : (chr_reg - 8'h30);
        end
        // finish result
        if (op == lts_pkg::OP_FCHK) begin
            sidx_reg   <= '0;
            ferr_reg   <= too_long;
            fecode_reg <= lts_pkg::ERR_LONG;
            fcode_reg  <= lts_pkg::CODE_KEYWORD + lts_pkg::CODE_W'(kw.idx);
        end
        if (op == lts_pkg::OP_CMP) begin
            sidx_reg <= sidx_inc;
            fcode_reg <= (is_ident ? lts_pkg::CODE_IDENT : lts_pkg::CODE_CONST)
                       + lts_pkg::CODE_W'(sidx_reg);
            ferr_reg <= 1'b0;
        end
        if (op == lts_pkg::OP_INS) begin
            ferr_reg   <= is_ident ? ifull : cfull;
            fecode_reg <= lts_pkg::ERR_FULL;
            fcode_reg  <= is_ident ? lts_pkg::CODE_IDENT + lts_pkg::CODE_W'(iused_reg)
                                   : lts_pkg::CODE_CONST + lts_pkg::CODE_W'(cused_reg);
        end
        // output beat
        if (e_en) begin
            okind_reg <= e_err;
            olast_reg <= (ridx_reg == (ntot_reg - 1'b1));
            odata_reg <= {5'd0, e_ecode, e_col, line_reg, e_len, e_code};
        end
    end

    // Symbol table memories
    always_ff @(posedge aclk) begin
        if ((op == lts_pkg::OP_INS) && is_ident && !ifull) begin
            imem[iused_reg[lts_pkg::IIDX_W-1:0]] <= {cnt_reg, name_reg};
        end
        if (op == lts_pkg::OP_SRCH) begin
            irow_reg <= imem[sidx_reg[lts_pkg::IIDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if ((op == lts_pkg::OP_INS) && !is_ident && !cfull) begin
            cmem[cused_reg[lts_pkg::CIDX_W-1:0]] <= {cnt_reg, cname};
        end
        if (op == lts_pkg::OP_SRCH) begin
            crow_reg <= cmem[sidx_reg[lts_pkg::CIDX_W-1:0]];
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

/* design/lts_ctrl.sv */
// Tokenizer controller: sequences decode, pre-result, table search,
// finish and restart steps of one item.
// Depends on lts_pkg.
`default_nettype none

module lts_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lts_pkg::status_t  st,
    output lts_pkg::op_t           op
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_PLAN  = 9'b000000010,
        ST_PRE   = 9'b000000100,
        ST_FCHK  = 9'b000001000,
        ST_SRCH  = 9'b000010000,
        ST_CMP   = 9'b000100000,
        ST_INS   = 9'b001000000,
        ST_FIN   = 9'b010000000,
        ST_START = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and command
    always_comb begin
        state_next = state_reg;
        op         = lts_pkg::OP_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op         = lts_pkg::OP_LOAD;
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN: begin
                op = lts_pkg::OP_PLAN;
                if (st.dec_pre != lts_pkg::PRE_NONE) state_next = ST_PRE;
                else if (st.dec_fin)                 state_next = ST_FCHK;
                else if (st.dec_start)               state_next = ST_START;
                else                                 state_next = ST_IDLE;
            end
            ST_PRE: begin
                if (st.out_free) begin
                    op = lts_pkg::OP_PRE;
                    if (st.fin)        state_next = ST_FCHK;
                    else if (st.start) state_next = ST_START;
                    else               state_next = ST_IDLE;
                end
            end
            ST_FCHK: begin
                op = lts_pkg::OP_FCHK;
                if (st.fin_direct)     state_next = ST_FIN;
                else if (st.used_zero) state_next = ST_INS;
                else                   state_next = ST_SRCH;
            end
            ST_SRCH: begin
                op         = lts_pkg::OP_SRCH;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                op = lts_pkg::OP_CMP;
                if (st.cmp_hit)        state_next = ST_FIN;
                else if (st.srch_last) state_next = ST_INS;
                else                   state_next = ST_SRCH;
            end
            ST_INS: begin
                op         = lts_pkg::OP_INS;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (st.out_free) begin
                    op         = lts_pkg::OP_FIN;
                    state_next = st.start ? ST_START : ST_IDLE;
                end
            end
            ST_START: begin
                if (!st.start_emits || st.out_free) begin
                    op         = lts_pkg::OP_START;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* design/lexical_tokenizer_with_symbol_tables_core.sv */
// Top level of the lexical tokenizer: controller plus datapath.
// Depends on lts_pkg, lts_ctrl, lts_dpath.
//
//   channel | dir | tdata                 | tuser     | tlast
//   s_      | in  | char_byte             | req_type  | -
//   m_      | out | code,len,line,col,err | out_kind  | last_result
//
// A character that continues a name or a comment, or an end marker with
// nothing pending, takes a load and a plan step; one that starts a token adds
// a start step, and a pre-result step when a '(' or an error beat goes first.
// Name ends add check and finish, an insert if new, a search+compare per entry.
// Reset (aresetn low, synchronous) empties both tables at once; no sweep.
// A result waiting in the output register holds the controller, and with it
// the input, until the receiver takes it.
`default_nettype none

module lexical_tokenizer_with_symbol_tables_core (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // char_byte
    input  wire logic                         s_tuser,   // req_type
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // token_code[9:0], name_length[15:10], line_number[31:16],
    // column_number[47:32], error_code[50:48], zero fill
    output logic [lts_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tuser,   // out_kind
    output logic                              m_tlast    // last_result
);

    lts_pkg::op_t     op;
    lts_pkg::status_t st;

    lts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .op       (op)
    );

    lts_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // One item at a time: an accepted beat closes the input until done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is in flight");

    // Token beats carry no error code
    a_tok_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[50:48] == 3'd0))
        else $error("token beat with error code");

    // Error beats carry zero code and length
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[15:0] == 16'd0))
        else $error("error beat with token code or length");

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the lexical tokenizer core: streams characters and
// end markers in, predicts tokens and errors, and checks every result beat.
// Depends on lts_pkg and lexical_tokenizer_with_symbol_tables_core.
`timescale 1ns / 1ps

module tb;

    typedef struct {
        bit       eoi;
        bit [7:0] ch;
    } char_item_t;

    typedef struct {
        bit        kind;
        bit [9:0]  code;
        bit [5:0]  len;
        bit [15:0] line;
        bit [15:0] col;
        bit [2:0]  err;
        bit        last;
    } tok_res_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;
    logic                         s_tuser = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [lts_pkg::TDATA_W-1:0]  m_tdata;
    logic                         m_tuser;
    logic                         m_tlast;

    char_item_t pend_q[$];
    tok_res_t   tok_q[$];
    tok_res_t   step_q[$];
    int         n_err = 0;
    int         n_chars = 0;
    int         n_tokens = 0;
    int         n_reports = 0;
    int         cyc = 0;

    // Scanner state mirror
    lts_pkg::mode_t sc_mode = lts_pkg::MD_IDLE;
    bit [7:0]  nm_buf [lts_pkg::MAX_NAME_LEN];
    int        nm_cnt = 0;
    int        cur_ln = 1;
    int        cur_col = 1;
    int        tok_col = 1;
    bit [7:0]  id_tab [lts_pkg::IDENT_DEPTH][lts_pkg::MAX_NAME_LEN];
    int        id_len [lts_pkg::IDENT_DEPTH];
    int        id_used = 0;
    bit [7:0]  cn_tab [lts_pkg::CONST_DEPTH][lts_pkg::MAX_NAME_LEN];
    int        cn_len [lts_pkg::CONST_DEPTH];
    int        cn_used = 0;
    string     kw_names [10] = '{"PROGRAM", "BEGIN", "END", "VA", "SIGNAL",
                                 "COMPLEX", "INTEGER", "FLOAT", "BLOCKFLOAT", "EXT"};
    string     delims = ";,:()";

    lexical_tokenizer_with_symbol_tables_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) cyc <= cyc + 1;

    function automatic bit is_letter(int c); return c >= "A" && c <= "Z"; endfunction
    function automatic bit is_digit(int c);  return c >= "0" && c <= "9"; endfunction
    function automatic bit is_space(int c);  return (c >= 8 && c <= 15) || c == 32; endfunction
    function automatic bit is_delim(int c);
        return c == ";" || c == "," || c == ":" || c == "(" || c == ")";
    endfunction

    function automatic void bump_col();
        if (cur_col < 65535) cur_col++;
    endfunction

    function automatic void advance_pos(int c);
        if (c == 10) begin
            if (cur_ln < 65535) cur_ln++;
            cur_col = 1;
        end else begin
            bump_col();
        end
    endfunction

    function automatic void emit(bit kind, int code, int len, int line, int col, int err);
        tok_res_t r;
        if (step_q.size() >= 2) return;
        r.kind = kind; r.code = 10'(code); r.len = 6'(len); r.line = 16'(line);
        r.col = 16'(col); r.err = 3'(err); r.last = 1'b0;
        step_q.insert(step_q.size(), r);
    endfunction

    function automatic void add_char(bit [7:0] v);
        if (nm_cnt < lts_pkg::MAX_NAME_LEN) begin
            nm_buf[nm_cnt] = v;
            nm_cnt++;
        end else begin
            nm_cnt = lts_pkg::MAX_NAME_LEN + 1;
        end
    endfunction

    // Look the pending name up in one table, adding it if new; -1 when full
    function automatic int intern_name(bit ident);
        int  used;
        bit  eq;
        used = ident ? id_used : cn_used;
        for (int e = 0; e < used; e++) begin
            eq = ((ident ? id_len[e] : cn_len[e]) == nm_cnt);
            for (int i = 0; i < nm_cnt && eq; i++)
                if ((ident ? id_tab[e][i] : cn_tab[e][i]) != nm_buf[i]) eq = 1'b0;
            if (eq) return e;
        end
        if (used >= (ident ? lts_pkg::IDENT_DEPTH : lts_pkg::CONST_DEPTH)) return -1;
        for (int i = 0; i < nm_cnt; i++) begin
            if (ident) id_tab[used][i] = nm_buf[i];
            else       cn_tab[used][i] = nm_buf[i];
        end
        if (ident) begin id_len[used] = nm_cnt; id_used++; end
        else       begin cn_len[used] = nm_cnt; cn_used++; end
        return used;
    endfunction

    function automatic void finish_name();
        int idx;
        int code;
        bit eq;
        idx = -1;
        code = 0;
        if (nm_cnt > lts_pkg::MAX_NAME_LEN) begin
            emit(1'b1, 0, 0, cur_ln, tok_col, lts_pkg::ERR_LONG);
        end else begin
            if (sc_mode == lts_pkg::MD_IDENT) begin
                for (int k = 0; k < 10 && idx < 0; k++) begin
                    eq = (kw_names[k].len() == nm_cnt);
                    for (int i = 0; i < nm_cnt && eq; i++)
                        if (kw_names[k][i] != nm_buf[i]) eq = 1'b0;
                    if (eq) idx = k;
                end
                if (idx >= 0) begin
                    code = lts_pkg::CODE_KEYWORD + idx;
                end else begin
                    idx = intern_name(1'b1);
                    code = lts_pkg::CODE_IDENT + idx;
                end
            end else begin
                idx = intern_name(1'b0);
                code = lts_pkg::CODE_CONST + idx;
            end
            if (idx < 0) emit(1'b1, 0, 0, cur_ln, tok_col, lts_pkg::ERR_FULL);
            else         emit(1'b0, code, nm_cnt, cur_ln, tok_col, 0);
        end
        sc_mode = lts_pkg::MD_IDLE;
        nm_cnt = 0;
    endfunction

    function automatic void start_char(int c);
        sc_mode = lts_pkg::MD_IDLE;
        if (is_space(c)) begin
            advance_pos(c);
        end else if (is_letter(c)) begin
            sc_mode = lts_pkg::MD_IDENT; nm_cnt = 0; tok_col = cur_col;
            add_char(8'(c)); bump_col();
        end else if (is_digit(c)) begin
            sc_mode = lts_pkg::MD_DIGIT; nm_cnt = 0; tok_col = cur_col;
            add_char(8'(c - "0")); bump_col();
        end else if (c == "(") begin
            sc_mode = lts_pkg::MD_PAREN; tok_col = cur_col; bump_col();
        end else if (is_delim(c)) begin
            emit(1'b0, c, 1, cur_ln, cur_col, 0); bump_col();
        end else begin
            emit(1'b1, 0, 0, cur_ln, cur_col, lts_pkg::ERR_BAD); bump_col();
        end
    endfunction

    // Advance the scanner mirror by one beat and queue the tokens it produces
    function automatic void tokenize_beat(bit eoi, bit [7:0] ch);
        int c;
        c = ch;
        step_q.delete();
        if (eoi) begin
            case (sc_mode)
                lts_pkg::MD_IDENT, lts_pkg::MD_DIGIT: finish_name();
                lts_pkg::MD_PAREN: emit(1'b0, "(", 1, cur_ln, tok_col, 0);
                lts_pkg::MD_COMMENT, lts_pkg::MD_STAR:
                    emit(1'b1, 0, 0, cur_ln, cur_col, lts_pkg::ERR_OPEN);
                default: ;
            endcase
            sc_mode = lts_pkg::MD_IDLE;
            nm_cnt = 0;
        end else begin
            case (sc_mode)
                lts_pkg::MD_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        add_char(8'(c)); bump_col();
                    end else begin
                        finish_name(); start_char(c);
                    end
                end
                lts_pkg::MD_DIGIT: begin
                    if (is_digit(c)) begin
                        add_char(8'(c - "0")); bump_col();
                    end else if (is_space(c) || is_delim(c)) begin
                        finish_name(); start_char(c);
                    end else begin
                        // non-digit, non-delimiter after digits: error first, then the constant
                        emit(1'b1, 0, 0, cur_ln, cur_col, lts_pkg::ERR_DELIM);
                        bump_col();
                        finish_name();
                    end
                end
                lts_pkg::MD_PAREN: begin
                    if (c == "*") begin
                        sc_mode = lts_pkg::MD_COMMENT; bump_col();
                    end else begin
                        emit(1'b0, "(", 1, cur_ln, tok_col, 0); start_char(c);
                    end
                end
                lts_pkg::MD_COMMENT: begin
                    if (c == "*") sc_mode = lts_pkg::MD_STAR;
                    advance_pos(c);
                end
                lts_pkg::MD_STAR: begin
                    if (c == ")") sc_mode = lts_pkg::MD_IDLE;
                    else if (c != "*") sc_mode = lts_pkg::MD_COMMENT;
                    advance_pos(c);
                end
                default: start_char(c);
            endcase
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
        foreach (step_q[i]) tok_q.insert(tok_q.size(), step_q[i]);
    endfunction

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                tokenize_beat(s_tuser, s_tdata);
                n_chars++;
            end
            if (pend_q.size() > 0 &&
                ((cyc >= 6000 && cyc < 9000) || $urandom_range(99) >= 17)) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pend_q[0].eoi;
                s_tdata  <= pend_q[0].ch;
                void'(pend_q.pop_front());
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, one long hold-off, one quiet stretch
    int rx_cyc = 0;
    always @(posedge aclk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc >= 3000 && rx_cyc < 3500)
            m_tready <= 1'b0;
        else
            m_tready <= (rx_cyc >= 6000 && rx_cyc < 9000) || ($urandom_range(99) >= 17);
    end

    task automatic report(string what, int got, int want);
        $display("ERROR t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
        n_err++;
    endtask

    // Result monitor
    always @(posedge aclk) begin
        tok_res_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (tok_q.size() == 0) begin
                report("unexpected result beat", m_tdata[9:0], -1);
            end else begin
                w = tok_q.pop_front();
                if (w.kind) n_reports++; else n_tokens++;
                if (m_tuser != w.kind)          report("out_kind", m_tuser, w.kind);
                if (m_tdata[9:0] != w.code)     report("token_code", m_tdata[9:0], w.code);
                if (m_tdata[15:10] != w.len)    report("name_length", m_tdata[15:10], w.len);
                if (m_tdata[31:16] != w.line)   report("line_number", m_tdata[31:16], w.line);
                if (m_tdata[47:32] != w.col)    report("column_number", m_tdata[47:32], w.col);
                if (m_tdata[50:48] != w.err)    report("error_code", m_tdata[50:48], w.err);
                if (m_tlast != w.last)          report("last_result", m_tlast, w.last);
            end
        end
    end

    task automatic put_ch(int c);
        char_item_t it;
        it.eoi = 1'b0; it.ch = 8'(c);
        pend_q.insert(pend_q.size(), it);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_ch(s[i]);
    endtask

    task automatic put_eoi();
        char_item_t it;
        it.eoi = 1'b1; it.ch = 8'($urandom_range(255));
        pend_q.insert(pend_q.size(), it);
    endtask

    task automatic put_name(bit digits, int len);
        for (int i = 0; i < len; i++) begin
            if (digits)              put_ch("0" + $urandom_range(9));
            else if (i == 0 || $urandom_range(3) != 0) put_ch("A" + $urandom_range(25));
            else                     put_ch("0" + $urandom_range(9));
        end
    endtask

    // Stimulus
    initial begin
        int sel;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: keywords, bounds of the letter and digit ranges, comments,
        // letter after digits, pending name at end, bad bytes, open comment
        put_str("EXT Z9,(*)*)12A:(B");
        put_eoi();
        put_ch(8'hFF); put_ch(8'h00); put_ch(10);
        put_str("(;(*");
        put_eoi();
        wait (pend_q.size() == 0 && !s_tvalid);
        wait (tok_q.size() == 0);
        repeat (5) @(posedge aclk);

        // Random: mostly well-formed token streams, some noise
        while (pend_q.size() < 1050) begin
            sel = $urandom_range(99);
            if (sel < 30)      put_name(1'b0, ($urandom_range(15) == 0) ? 17 + $urandom_range(3)
                                                                       : 1 + $urandom_range(5));
            else if (sel < 40) put_str(kw_names[$urandom_range(9)]);
            else if (sel < 55) put_name(1'b1, ($urandom_range(15) == 0) ? 17 : 1 + $urandom_range(3));
            else if (sel < 65) begin
                put_str("(*");
                repeat ($urandom_range(4)) put_ch($urandom_range(2) == 0 ? "*" : $urandom_range(255));
                if ($urandom_range(7) != 0) put_str("*)");
            end
            else if (sel < 72) put_ch(10);
            else if (sel < 77) put_ch($urandom_range(255));
            else if (sel < 80) put_eoi();
            if ($urandom_range(9) < 6) put_ch(" ");
            else if ($urandom_range(9) < 8) put_ch(delims[$urandom_range(4)]);
        end
        put_eoi();

        wait (pend_q.size() == 0 && !s_tvalid);
        wait (tok_q.size() == 0);
        repeat (300) @(posedge aclk);
        $display("Sent %0d beats; checked %0d tokens and %0d error reports.",
                 n_chars, n_tokens, n_reports);
        $display("Identifier table held %0d names, constant table %0d.", id_used, cn_used);
        if (n_err == 0 && tok_q.size() == 0)
            $display("lexical_tokenizer_with_symbol_tables_core: match");
        else
            $display("lexical_tokenizer_with_symbol_tables_core: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #50ms;
        $display("Timeout with %0d results outstanding", tok_q.size());
        $display("lexical_tokenizer_with_symbol_tables_core: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/lts_pkg.sv
design/lts_dpath.sv
design/lts_ctrl.sv
design/lexical_tokenizer_with_symbol_tables_core.sv
dv/tb.sv
